// ===== src/mesicf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MESI cache package
// Shared types, codes and handshake structs for the MESI cache core.
// ----------------------------------------------------------------------------
package mesicf_pkg;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SNOOP = 2'd2;
	localparam logic [1:0] OP_UNDEF = 2'd3;

	localparam logic [1:0] MESI_I = 2'd0;
	localparam logic [1:0] MESI_S = 2'd1;
	localparam logic [1:0] MESI_E = 2'd2;
	localparam logic [1:0] MESI_M = 2'd3;

	localparam logic [1:0] BUS_NONE = 2'd0;
	localparam logic [1:0] BUS_RD   = 2'd1;
	localparam logic [1:0] BUS_RDX  = 2'd2;
	localparam logic [1:0] BUS_UPGR = 2'd3;

	localparam logic [1:0] CLS_NONE     = 2'd0;
	localparam logic [1:0] CLS_FILTERED = 2'd1;
	localparam logic [1:0] CLS_WASTED   = 2'd2;
	localparam logic [1:0] CLS_USEFUL   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] addr;
		logic [1:0]  bus_signal;
		logic        other_copy;
	} in_item_t;

	typedef struct packed {
		logic [1:0] bus_request;
		logic       hit;
		logic       victim_writeback;
		logic       from_cache;
		logic [1:0] snoop_class;
		logic       invalidated;
		logic       intervention;
		logic       flush;
		logic [1:0] line_state;
	} out_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ===== src/mesicf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mesicf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/mesicf_ctl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MESI cache controller
// Sequences lookup and commit of one transaction at a time.
// ----------------------------------------------------------------------------
module mesicf_ctl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mesicf_pkg::ctl_sts_t sts,
	output mesicf_pkg::ctl_cmd_t     cmd
);
	mesicf_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mesicf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			mesicf_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = mesicf_pkg::ST_LOOK;
				end
			end
			mesicf_pkg::ST_LOOK: begin
				// Hold here while the result register is occupied and not being taken.
				cmd.commit = sts.out_free;
				if (sts.out_free) begin
					state_d = mesicf_pkg::ST_IDLE;
				end
			end
			default: state_d = mesicf_pkg::ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/mesicf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MESI cache datapath
// Line store RAM, snoop filter registers, protocol and LRU update logic.
// ----------------------------------------------------------------------------
module mesicf_dp #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int FILTER_SETS = 8,
	parameter int FILTER_WAYS = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mesicf_pkg::ctl_cmd_t  cmd,
	output mesicf_pkg::ctl_sts_t       sts,
	input  wire mesicf_pkg::in_item_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output mesicf_pkg::out_item_t      out_data
);
	localparam int OFF_W   = $clog2(BLOCK_BYTES);
	localparam int BLK_W   = 32 - OFF_W;
	localparam int SET_LG  = $clog2(SETS);
	localparam int SET_W   = (SETS > 1) ? SET_LG : 1;
	localparam int CTAG_W  = BLK_W - SET_LG;
	localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W   = WIDX_W;
	localparam int WAY_W   = CTAG_W + 2 + AGE_W;
	localparam int ROW_W   = WAYS * WAY_W;
	localparam int FSET_LG = $clog2(FILTER_SETS);
	localparam int FSET_W  = (FILTER_SETS > 1) ? FSET_LG : 1;
	localparam int FTAG_W  = BLK_W - FSET_LG;
	localparam int FIDX_W  = (FILTER_WAYS > 1) ? $clog2(FILTER_WAYS) : 1;
	localparam int FAGE_W  = FIDX_W;

	// Captured transaction.
	mesicf_pkg::in_item_t item_q;

	logic [BLK_W-1:0]  in_block, blk;
	logic [SET_W-1:0]  in_set, set;
	logic [CTAG_W-1:0] ctag;
	logic [FSET_W-1:0] fset;
	logic [FTAG_W-1:0] ftag;

	assign in_block = in_data.addr[31:OFF_W];
	assign in_set   = (SETS > 1) ? in_block[SET_W-1:0] : '0;
	assign blk      = item_q.addr[31:OFF_W];
	assign set      = (SETS > 1) ? blk[SET_W-1:0] : '0;
	assign ctag     = CTAG_W'(blk >> SET_LG);
	assign fset     = (FILTER_SETS > 1) ? blk[FSET_W-1:0] : '0;
	assign ftag     = FTAG_W'(blk >> FSET_LG);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_data;
		end
	end

	// Line store: one row per set holds tag, state and age of every way.
	logic [ROW_W-1:0] row_rd, row_wr;
	logic [SETS-1:0]  row_vld_q;

	mesicf_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_lines (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (set),
		.wdata (row_wr),
		.re    (cmd.capture),
		.raddr (in_set),
		.rdata (row_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.commit) begin
			row_vld_q[set] <= 1'b1;
		end
	end

	// Snoop filter in registers.
	logic [FTAG_W-1:0] f_tag_q [FILTER_SETS][FILTER_WAYS];
	logic              f_vld_q [FILTER_SETS][FILTER_WAYS];
	logic [FAGE_W-1:0] f_age_q [FILTER_SETS][FILTER_WAYS];

	logic [CTAG_W-1:0] tag_o [WAYS];
	logic [1:0]        st_o  [WAYS];
	logic [AGE_W-1:0]  age_o [WAYS];
	logic [1:0]        st_n  [WAYS];
	logic [CTAG_W-1:0] tag_n [WAYS];
	logic [AGE_W-1:0]  age_n [WAYS];
	logic              f_vld_n [FILTER_WAYS];
	logic [FAGE_W-1:0] f_age_n [FILTER_WAYS];
	logic              f_wr_tag;
	logic [FIDX_W-1:0] f_wr_way;
	mesicf_pkg::out_item_t res;

	always_comb begin
		logic              found, ffound, have_inv, do_touch, do_ftouch, f_insert;
		logic [WIDX_W-1:0] hw, iw, ow, tw;
		logic [FIDX_W-1:0] fw, fiw, fow, ftw;
		logic              f_have_inv;
		logic [1:0]        cur, ns;
		logic [AGE_W-1:0]  ref_age;
		logic [FAGE_W-1:0] fref_age;

		for (int j = 0; j < WAYS; j++) begin
			tag_o[j] = row_rd[j*WAY_W + AGE_W + 2 +: CTAG_W];
			st_o[j]  = row_vld_q[set] ? row_rd[j*WAY_W + AGE_W +: 2] : mesicf_pkg::MESI_I;
			age_o[j] = row_vld_q[set] ? row_rd[j*WAY_W +: AGE_W] : '0;
			tag_n[j] = tag_o[j];
			st_n[j]  = st_o[j];
		end
		for (int j = 0; j < FILTER_WAYS; j++) begin
			f_vld_n[j] = f_vld_q[fset][j];
		end

		found = 1'b0;
		hw    = '0;
		have_inv = 1'b0;
		iw    = '0;
		ow    = '0;
		for (int j = WAYS - 1; j >= 0; j--) begin
			if (st_o[j] != mesicf_pkg::MESI_I && tag_o[j] == ctag) begin
				found = 1'b1;
				hw    = WIDX_W'(j);
			end
			if (st_o[j] == mesicf_pkg::MESI_I) begin
				have_inv = 1'b1;
				iw       = WIDX_W'(j);
			end
		end
		for (int j = 1; j < WAYS; j++) begin
			if (age_o[j] > age_o[ow]) begin
				ow = WIDX_W'(j);
			end
		end

		ffound = 1'b0;
		fw     = '0;
		f_have_inv = 1'b0;
		fiw    = '0;
		fow    = '0;
		for (int j = FILTER_WAYS - 1; j >= 0; j--) begin
			if (f_vld_q[fset][j] && f_tag_q[fset][j] == ftag) begin
				ffound = 1'b1;
				fw     = FIDX_W'(j);
			end
			if (!f_vld_q[fset][j]) begin
				f_have_inv = 1'b1;
				fiw        = FIDX_W'(j);
			end
		end
		for (int j = 1; j < FILTER_WAYS; j++) begin
			if (f_age_q[fset][j] > f_age_q[fset][fow]) begin
				fow = FIDX_W'(j);
			end
		end

		res       = '0;
		do_touch  = 1'b0;
		tw        = hw;
		do_ftouch = 1'b0;
		ftw       = fw;
		f_insert  = 1'b0;
		cur       = found ? st_o[hw] : mesicf_pkg::MESI_I;
		ns        = cur;

		case (item_q.op)
			mesicf_pkg::OP_READ, mesicf_pkg::OP_WRITE: begin
				do_touch = 1'b1;
				if (found) begin
					res.hit = 1'b1;
					if (item_q.op == mesicf_pkg::OP_WRITE) begin
						if (cur == mesicf_pkg::MESI_S) begin
							res.bus_request = mesicf_pkg::BUS_UPGR;
						end
						st_n[hw] = mesicf_pkg::MESI_M;
					end
					res.line_state = st_n[hw];
				end else begin
					// A local miss drops the block from the filter.
					if (ffound) begin
						f_vld_n[fw] = 1'b0;
					end
					res.from_cache = item_q.other_copy;
					tw = have_inv ? iw : ow;
					res.victim_writeback = (st_o[tw] == mesicf_pkg::MESI_M);
					tag_n[tw] = ctag;
					if (item_q.op == mesicf_pkg::OP_WRITE) begin
						res.bus_request = mesicf_pkg::BUS_RDX;
						res.line_state  = mesicf_pkg::MESI_M;
					end else begin
						res.bus_request = mesicf_pkg::BUS_RD;
						res.line_state  = item_q.other_copy ? mesicf_pkg::MESI_S
						                                    : mesicf_pkg::MESI_E;
					end
					st_n[tw] = res.line_state;
				end
			end
			mesicf_pkg::OP_SNOOP: begin
				res.line_state = cur;
				if (item_q.bus_signal != mesicf_pkg::BUS_NONE) begin
					if (ffound) begin
						res.snoop_class = mesicf_pkg::CLS_FILTERED;
						do_ftouch = 1'b1;
					end else if (!found) begin
						res.snoop_class = mesicf_pkg::CLS_WASTED;
						f_insert = 1'b1;
					end else begin
						res.snoop_class = mesicf_pkg::CLS_USEFUL;
						case (cur)
							mesicf_pkg::MESI_S: begin
								if (item_q.bus_signal == mesicf_pkg::BUS_RDX ||
								    item_q.bus_signal == mesicf_pkg::BUS_UPGR) begin
									ns = mesicf_pkg::MESI_I;
								end
							end
							mesicf_pkg::MESI_E: begin
								if (item_q.bus_signal == mesicf_pkg::BUS_RDX) begin
									ns = mesicf_pkg::MESI_I;
								end else if (item_q.bus_signal == mesicf_pkg::BUS_RD) begin
									ns = mesicf_pkg::MESI_S;
									res.intervention = 1'b1;
								end
							end
							mesicf_pkg::MESI_M: begin
								if (item_q.bus_signal == mesicf_pkg::BUS_RDX) begin
									ns = mesicf_pkg::MESI_I;
									res.flush = 1'b1;
								end else if (item_q.bus_signal == mesicf_pkg::BUS_RD) begin
									ns = mesicf_pkg::MESI_S;
									res.intervention = 1'b1;
									res.flush = 1'b1;
								end
							end
							default: ns = cur;
						endcase
						if (ns == mesicf_pkg::MESI_I) begin
							res.invalidated = 1'b1;
							f_insert = 1'b1;
						end
						st_n[hw] = ns;
						res.line_state = ns;
					end
				end
			end
			default: res = '0;
		endcase

		// Filter insert: reuse a matching entry, else first free, else LRU.
		f_wr_tag = 1'b0;
		f_wr_way = fw;
		if (f_insert) begin
			do_ftouch = 1'b1;
			if (ffound) begin
				ftw = fw;
			end else begin
				ftw = f_have_inv ? fiw : fow;
				f_wr_tag = 1'b1;
				f_vld_n[ftw] = 1'b1;
			end
			f_wr_way = ftw;
		end

		// True-LRU age update for the cache set and the filter set.
		ref_age = age_o[tw];
		for (int j = 0; j < WAYS; j++) begin
			age_n[j] = age_o[j];
			if (do_touch) begin
				if (WIDX_W'(j) == tw) begin
					age_n[j] = '0;
				end else if (age_o[j] <= ref_age) begin
					age_n[j] = age_o[j] + AGE_W'(1);
				end
			end
		end
		fref_age = f_age_q[fset][ftw];
		for (int j = 0; j < FILTER_WAYS; j++) begin
			f_age_n[j] = f_age_q[fset][j];
			if (do_ftouch) begin
				if (FIDX_W'(j) == ftw) begin
					f_age_n[j] = '0;
				end else if (f_age_q[fset][j] <= fref_age) begin
					f_age_n[j] = f_age_q[fset][j] + FAGE_W'(1);
				end
			end
		end

		for (int j = 0; j < WAYS; j++) begin
			row_wr[j*WAY_W +: WAY_W] = {tag_n[j], st_n[j], age_n[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < FILTER_SETS; s++) begin
				for (int j = 0; j < FILTER_WAYS; j++) begin
					f_vld_q[s][j] <= 1'b0;
					f_age_q[s][j] <= '0;
				end
			end
		end else if (cmd.commit) begin
			for (int j = 0; j < FILTER_WAYS; j++) begin
				f_vld_q[fset][j] <= f_vld_n[j];
				f_age_q[fset][j] <= f_age_n[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && f_wr_tag) begin
			f_tag_q[fset][f_wr_way] <= ftag;
		end
	end

	// Result register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ===== src/mesi_cache_with_snoop_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// MESI cache with snoop filter
// Set-associative MESI cache controller with true-LRU replacement and a
// small history filter that drops snoops for blocks known to be absent.
// ----------------------------------------------------------------------------
// Usage:
// in_valid/in_ready carry one processor read, write or bus snoop per
// transaction; out_valid/out_ready return exactly one result per transaction.
// The core reads the set row from the line RAM (registered read port) when
// it accepts a transaction, then updates the row and the filter and loads
// the result register. The next transaction is accepted the cycle after that,
// so a new transaction is taken only once the last one has committed.
// A finished result waits in the output register while a new transaction is
// accepted; if the receiver still holds off when that one is ready to
// commit, the core waits until the result register frees up.
// Reset clears all line valid bits (per set row), the filter and all LRU
// ages; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mesi_cache_with_snoop_filter_core #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int BLOCK_BYTES = 64,
	parameter int FILTER_SETS = 8,
	parameter int FILTER_WAYS = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire mesicf_pkg::in_item_t  in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output mesicf_pkg::out_item_t      out_data
);
	mesicf_pkg::ctl_cmd_t cmd;
	mesicf_pkg::ctl_sts_t sts;

	mesicf_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mesicf_dp #(
		.SETS        (SETS),
		.WAYS        (WAYS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.FILTER_SETS (FILTER_SETS),
		.FILTER_WAYS (FILTER_WAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// One transaction in flight at a time.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction accepted while another was in flight");

	a_hit_not_snoop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hit |-> out_data.snoop_class == mesicf_pkg::CLS_NONE)
		else $error("hit reported together with a snoop class");

	a_inv_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.invalidated |-> out_data.line_state == mesicf_pkg::MESI_I)
		else $error("invalidation left the line valid");

	a_wb_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.victim_writeback |-> !out_data.hit)
		else $error("victim writeback reported on a hit");
endmodule
`default_nettype wire
